>>> src/adaptive_period_meter_unit_assert.svh
// adaptive_period_meter_unit_assert.svh: assertion macros for the period meter checker
// depends on nothing; taken in by the checker through `include
`ifndef ADAPTIVE_PERIOD_METER_UNIT_ASSERT_SVH
`define ADAPTIVE_PERIOD_METER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define APM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define APM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/apm_pkg.sv
// apm_pkg: shared constants, codes and controller/datapath types of the period meter
// depends on nothing
`timescale 1ns / 1ps

package apm_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int CMD_W     = 2;
  localparam int WEIGHT_W  = 16;
  localparam int SUM_W     = 48;
  localparam int ADS_W     = 64;
  localparam int PER_W     = 32;
  localparam int TOTAL_W   = 48;
  localparam int AMP_W     = 24;
  localparam int AVGP_W    = 40;
  localparam int DIVCFG_W  = 8;
  localparam int WARM_W    = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // shared divider operand widths
  localparam int DVD_W = ADS_W;
  localparam int DVS_W = SUM_W;

  localparam logic [DIVCFG_W-1:0] DIVISOR_RST = 8'd10;
  localparam logic [WARM_W-1:0]   WARMUP_RST  = 4'd2;

  // item command codes
  localparam logic [CMD_W-1:0] CMD_FEED  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    DSEL_AVG,
    DSEL_AMP,
    DSEL_THR,
    DSEL_PER
  } dsel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_CAP,
    S_CLEAR,
    S_SUMS,
    S_AVG_GO,
    S_AVG_WAIT,
    S_DEV,
    S_MUL,
    S_ADS,
    S_AMP_GO,
    S_AMP_WAIT,
    S_THR_GO,
    S_THR_WAIT,
    S_EDGE,
    S_PER_GO,
    S_PER_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic  load_item;
    logic  do_sums;
    logic  do_dev;
    logic  do_mul;
    logic  do_ads;
    logic  do_edge;
    logic  do_clear;
    logic  do_pop_rd;
    logic  do_pop_cap;
    logic  div_start;
    logic  div_cap;
    dsel_t div_sel;
    logic  load_out;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             queue_empty;
    logic             div_done;
  } sts_t;

endpackage

>>> src/apm_ram.sv
// apm_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps

module apm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/apm_div.sv
// apm_div: shared restoring divider, one quotient bit per cycle
// depends on apm_pkg for the operand widths
`timescale 1ns / 1ps

module apm_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [apm_pkg::DVD_W-1:0] dividend,
  input  logic [apm_pkg::DVS_W-1:0] divisor,
  output logic                     done,
  output logic [apm_pkg::DVD_W-1:0] quotient
);
  import apm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem, quotient[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

>>> src/apm_dp.sv
// apm_dp: datapath of the period meter - sums, divider, edge logic, statistics, queue
// depends on apm_pkg, apm_div and apm_ram
`timescale 1ns / 1ps

module apm_dp #(
  parameter int QUEUE_DEPTH = apm_pkg::QUEUE_DEPTH_DEF,
  parameter int SAMPLE_BITS = apm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = apm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apm_pkg::PADDR_W-1:0]       paddr,
  input  logic [apm_pkg::PDATA_W-1:0]       pwdata,
  output logic [apm_pkg::PDATA_W-1:0]       prdata,
  input  logic [apm_pkg::CMD_W-1:0]         cmd,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic [apm_pkg::WEIGHT_W-1:0]      weight,
  input  apm_pkg::ctl_t                     ctl,
  output apm_pkg::sts_t                     sts,
  output logic                              period_valid,
  output logic [apm_pkg::PER_W-1:0]         last_period,
  output logic [apm_pkg::PER_W-1:0]         min_period,
  output logic [apm_pkg::PER_W-1:0]         max_period,
  output logic [apm_pkg::PER_W-1:0]         period_count,
  output logic [apm_pkg::AVGP_W-1:0]        average_period,
  output logic [apm_pkg::AMP_W-1:0]         amplitude,
  output logic                              ready_res,
  output logic                              pop_valid,
  output logic [apm_pkg::PER_W-1:0]         pop_value,
  output logic                              overflow,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level
);
  import apm_pkg::*;

  localparam int QA_W    = $clog2(QUEUE_DEPTH);
  localparam int LVL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int TERM_W  = SAMPLE_BITS + WEIGHT_W + 1;
  localparam int EXT_W   = (TERM_W > SUM_W ? TERM_W : SUM_W) + 1;
  localparam int AVG_W   = SAMPLE_BITS + FRAC_BITS;
  localparam int DELTA_W = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int MAG_W   = DELTA_W - 1;
  localparam int PROD_W  = MAG_W + WEIGHT_W;
  localparam int ADSX_W  = (PROD_W > ADS_W ? PROD_W : ADS_W) + 1;
  localparam int CMP_W   = (DELTA_W > AMP_W + 1 ? DELTA_W : AMP_W + 1);

  localparam logic [1:0] POL_NEUTRAL = 2'd0;
  localparam logic [1:0] POL_POS     = 2'd1;
  localparam logic [1:0] POL_NEG     = 2'd2;

  localparam logic REG_DIVISOR = 1'b0;
  localparam logic REG_WARMUP  = 1'b1;

  // configuration
  logic [DIVCFG_W-1:0] divisor_cfg;
  logic [WARM_W-1:0]   warmup_cfg;

  // item in work
  logic [CMD_W-1:0]            item_cmd;
  logic signed [SAMPLE_BITS-1:0] item_sample;
  logic [WEIGHT_W-1:0]         item_weight;

  // running state
  logic signed [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0]        weight_total;
  logic [ADS_W-1:0]        abs_dev_sum;
  logic [1:0]              polarity;
  logic [PER_W-1:0]        since_rise;
  logic [WARM_W-1:0]       warmup_left;
  logic [PER_W-1:0]        recent_period;
  logic [PER_W-1:0]        shortest;
  logic [PER_W-1:0]        longest;
  logic [TOTAL_W-1:0]      period_total;
  logic [PER_W-1:0]        periods_seen;
  logic [QA_W-1:0]         queue_head;
  logic [QA_W-1:0]         queue_tail;
  logic [LVL_W-1:0]        queue_fill;
  logic                    dropped_flag;

  // intermediate results
  logic [AVG_W-1:0]          avg_mag;
  logic                      avg_neg;
  logic signed [DELTA_W-1:0] delta;
  logic [PROD_W-1:0]         prod;
  logic [AMP_W-1:0]          amp_val;
  logic [AMP_W-1:0]          thr_val;
  logic [AVGP_W-1:0]         avgp_val;
  logic                      period_rec;
  logic                      pop_v;
  logic [PER_W-1:0]          pop_val;

  // divider
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  // ram
  logic             ram_we;
  logic [PER_W-1:0] ram_rdata;

  // ---------------- configuration port ----------------
  logic cfg_we;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_cfg <= DIVISOR_RST;
      warmup_cfg  <= WARMUP_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_DIVISOR: divisor_cfg <= pwdata[DIVCFG_W-1:0];
        REG_WARMUP:  warmup_cfg  <= pwdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DIVISOR: prdata = PDATA_W'(divisor_cfg);
      REG_WARMUP:  prdata = PDATA_W'(warmup_cfg);
      default:     prdata = '0;
    endcase
  end

  // ---------------- sums ----------------
  logic signed [TERM_W-1:0] term;
  logic signed [EXT_W-1:0]  sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic [SUM_W:0]           wt_ext;
  logic [SUM_W-1:0]         wt_sat;

  assign term    = item_sample * $signed({1'b0, item_weight});
  assign sum_ext = EXT_W'(sample_sum) + EXT_W'(term);
  assign wt_ext  = {1'b0, weight_total} + (SUM_W + 1)'(item_weight);
  assign wt_sat  = wt_ext[SUM_W] ? '1 : wt_ext[SUM_W-1:0];

  always_comb begin
    if (&sum_ext[EXT_W-1:SUM_W-1] || ~|sum_ext[EXT_W-1:SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W-1:0];
    end else if (sum_ext[EXT_W-1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  // ---------------- deviation ----------------
  logic [SUM_W-1:0]          abs_sum;
  logic signed [DELTA_W-1:0] sample_fx;
  logic signed [DELTA_W-1:0] avg_ext;
  logic [MAG_W-1:0]          mag;
  logic [ADSX_W-1:0]         ads_ext;

  assign abs_sum   = sample_sum[SUM_W-1] ? SUM_W'(-sample_sum) : SUM_W'(sample_sum);
  assign sample_fx = DELTA_W'(item_sample) <<< FRAC_BITS;
  assign avg_ext   = $signed({2'b00, avg_mag});
  assign mag       = delta[DELTA_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
  assign ads_ext   = ADSX_W'(abs_dev_sum) + ADSX_W'(prod);

  // ---------------- divider ----------------
  always_comb begin
    case (ctl.div_sel)
      DSEL_AVG: begin
        div_dvd = DVD_W'(abs_sum) << FRAC_BITS;
        div_dvs = weight_total;
      end
      DSEL_AMP: begin
        div_dvd = abs_dev_sum;
        div_dvs = weight_total;
      end
      DSEL_THR: begin
        div_dvd = DVD_W'(amp_val);
        div_dvs = (divisor_cfg == '0) ? DVS_W'(1) : DVS_W'(divisor_cfg);
      end
      DSEL_PER: begin
        div_dvd = DVD_W'(period_total) << FRAC_BITS;
        div_dvs = DVS_W'(periods_seen);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  apm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------- edge detection ----------------
  logic signed [CMP_W-1:0] delta_c;
  logic signed [CMP_W-1:0] thr_c;
  logic [1:0]              pol_new;
  logic [PER_W-1:0]        sr_next;
  logic [WARM_W-1:0]       wl_next;
  logic                    rec;
  logic [PER_W:0]          sr_sum;

  assign delta_c = CMP_W'(delta);
  assign thr_c   = $signed(CMP_W'({1'b0, thr_val}));

  always_comb begin
    if (delta_c > thr_c) begin
      pol_new = POL_POS;
    end else if (delta_c < -thr_c) begin
      pol_new = POL_NEG;
    end else begin
      pol_new = POL_NEUTRAL;
    end
  end

  always_comb begin
    sr_next = since_rise;
    wl_next = warmup_left;
    rec     = 1'b0;
    if (pol_new != polarity && pol_new == POL_POS) begin
      if (since_rise != '0) begin
        sr_next = '0;
        rec     = (warmup_left == '0);
      end
      if (warmup_left != '0) begin
        wl_next = warmup_left - WARM_W'(1);
      end
    end
    sr_sum = {1'b0, sr_next} + (PER_W + 1)'(item_weight);
    if (wl_next == '0) begin
      sr_next = sr_sum[PER_W] ? '1 : sr_sum[PER_W-1:0];
    end
  end

  // period statistics for a recorded period (since_rise is the period)
  logic [TOTAL_W:0]   tot_ext;
  logic [PER_W-1:0]   seen_next;
  logic               first_rec;
  logic               queue_full;

  assign tot_ext    = {1'b0, period_total} + (TOTAL_W + 1)'(since_rise);
  assign seen_next  = (&periods_seen) ? periods_seen : periods_seen + PER_W'(1);
  assign first_rec  = (seen_next == PER_W'(1));
  assign queue_full = (queue_fill == LVL_W'(QUEUE_DEPTH));
  assign ram_we     = ctl.do_edge & rec & ~queue_full;

  apm_ram #(
    .WIDTH (PER_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (queue_tail),
    .wdata (since_rise),
    .re    (ctl.do_pop_rd),
    .raddr (queue_head),
    .rdata (ram_rdata)
  );

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      weight_total  <= '0;
      abs_dev_sum   <= '0;
      polarity      <= POL_NEUTRAL;
      since_rise    <= '0;
      warmup_left   <= WARMUP_RST;
      recent_period <= '0;
      shortest      <= '0;
      longest       <= '0;
      period_total  <= '0;
      periods_seen  <= '0;
      queue_head    <= '0;
      queue_tail    <= '0;
      queue_fill    <= '0;
      dropped_flag  <= 1'b0;
    end else begin
      if (ctl.do_clear) begin
        sample_sum    <= '0;
        weight_total  <= '0;
        abs_dev_sum   <= '0;
        polarity      <= POL_NEUTRAL;
        since_rise    <= '0;
        warmup_left   <= warmup_cfg;
        recent_period <= '0;
        shortest      <= '0;
        longest       <= '0;
        period_total  <= '0;
        periods_seen  <= '0;
      end
      if (ctl.do_sums) begin
        sample_sum   <= sum_sat;
        weight_total <= wt_sat;
      end
      if (ctl.do_ads) begin
        abs_dev_sum <= (|ads_ext[ADSX_W-1:ADS_W]) ? '1 : ads_ext[ADS_W-1:0];
      end
      if (ctl.do_edge) begin
        polarity    <= pol_new;
        since_rise  <= sr_next;
        warmup_left <= wl_next;
        if (rec) begin
          recent_period <= since_rise;
          period_total  <= tot_ext[TOTAL_W] ? '1 : tot_ext[TOTAL_W-1:0];
          periods_seen  <= seen_next;
          if (first_rec || since_rise < shortest) begin
            shortest <= since_rise;
          end
          if (first_rec || since_rise > longest) begin
            longest <= since_rise;
          end
          if (queue_full) begin
            dropped_flag <= 1'b1;
          end else begin
            queue_tail <= (queue_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : queue_tail + QA_W'(1);
            queue_fill <= queue_fill + LVL_W'(1);
          end
        end
      end
      if (ctl.do_pop_rd) begin
        queue_head <= (queue_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : queue_head + QA_W'(1);
        queue_fill <= queue_fill - LVL_W'(1);
      end
    end
  end

  // item capture, per-item flags and intermediate values
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd    <= cmd;
      item_sample <= sample;
      item_weight <= weight;
      period_rec  <= 1'b0;
      pop_v       <= 1'b0;
      pop_val     <= '0;
    end
    if (ctl.do_edge) begin
      period_rec <= rec;
    end
    if (ctl.do_pop_rd) begin
      pop_v <= 1'b1;
    end
    if (ctl.do_pop_cap) begin
      pop_val <= ram_rdata;
    end
    if (ctl.do_dev) begin
      delta <= sample_fx - (avg_neg ? -avg_ext : avg_ext);
    end
    if (ctl.do_mul) begin
      prod <= PROD_W'(mag) * PROD_W'(item_weight);
    end
    if (ctl.div_cap) begin
      case (ctl.div_sel)
        DSEL_AVG: begin
          avg_mag <= (weight_total == '0) ? '0 : div_quo[AVG_W-1:0];
          avg_neg <= sample_sum[SUM_W-1];
        end
        DSEL_AMP: begin
          if (weight_total == '0) begin
            amp_val <= '0;
          end else begin
            amp_val <= (|div_quo[DVD_W-1:AMP_W]) ? '1 : div_quo[AMP_W-1:0];
          end
        end
        DSEL_THR: thr_val <= div_quo[AMP_W-1:0];
        DSEL_PER: begin
          if (periods_seen == '0) begin
            avgp_val <= '0;
          end else begin
            avgp_val <= (|div_quo[DVD_W-1:AVGP_W]) ? '1 : div_quo[AVGP_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      period_valid   <= period_rec;
      last_period    <= recent_period;
      min_period     <= shortest;
      max_period     <= longest;
      period_count   <= periods_seen;
      average_period <= avgp_val;
      amplitude      <= amp_val;
      ready_res      <= (periods_seen != '0);
      pop_valid      <= pop_v;
      pop_value      <= pop_val;
      overflow       <= dropped_flag;
      queue_level    <= queue_fill;
    end
  end

  assign sts.item_cmd    = item_cmd;
  assign sts.queue_empty = (queue_fill == '0);
  assign sts.div_done    = div_done;

endmodule

>>> src/apm_ctrl.sv
// apm_ctrl: sequencing state machine of the period meter
// depends on apm_pkg
`timescale 1ns / 1ps

module apm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  apm_pkg::sts_t sts,
  output apm_pkg::ctl_t ctl
);
  import apm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.div_sel = DSEL_AMP;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.item_cmd)
          CMD_FEED:  state_next = S_SUMS;
          CMD_POP:   state_next = sts.queue_empty ? S_AMP_GO : S_POP_RD;
          CMD_CLEAR: state_next = S_CLEAR;
          default:   state_next = S_AMP_GO;
        endcase
      end
      S_POP_RD: begin
        ctl.do_pop_rd = 1'b1;
        state_next    = S_POP_CAP;
      end
      S_POP_CAP: begin
        ctl.do_pop_cap = 1'b1;
        state_next     = S_AMP_GO;
      end
      S_CLEAR: begin
        ctl.do_clear = 1'b1;
        state_next   = S_AMP_GO;
      end
      S_SUMS: begin
        ctl.do_sums = 1'b1;
        state_next  = S_AVG_GO;
      end
      S_AVG_GO: begin
        ctl.div_sel   = DSEL_AVG;
        ctl.div_start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        ctl.div_sel = DSEL_AVG;
        if (sts.div_done) begin
          ctl.div_cap = 1'b1;
          state_next  = S_DEV;
        end
      end
      S_DEV: begin
        ctl.do_dev = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.do_mul = 1'b1;
        state_next = S_ADS;
      end
      S_ADS: begin
        ctl.do_ads = 1'b1;
        state_next = S_AMP_GO;
      end
      S_AMP_GO: begin
        ctl.div_sel   = DSEL_AMP;
        ctl.div_start = 1'b1;
        state_next    = S_AMP_WAIT;
      end
      S_AMP_WAIT: begin
        ctl.div_sel = DSEL_AMP;
        if (sts.div_done) begin
          ctl.div_cap = 1'b1;
          state_next  = (sts.item_cmd == CMD_FEED) ? S_THR_GO : S_PER_GO;
        end
      end
      S_THR_GO: begin
        ctl.div_sel   = DSEL_THR;
        ctl.div_start = 1'b1;
        state_next    = S_THR_WAIT;
      end
      S_THR_WAIT: begin
        ctl.div_sel = DSEL_THR;
        if (sts.div_done) begin
          ctl.div_cap = 1'b1;
          state_next  = S_EDGE;
        end
      end
      S_EDGE: begin
        ctl.do_edge = 1'b1;
        state_next  = S_PER_GO;
      end
      S_PER_GO: begin
        ctl.div_sel   = DSEL_PER;
        ctl.div_start = 1'b1;
        state_next    = S_PER_WAIT;
      end
      S_PER_WAIT: begin
        ctl.div_sel = DSEL_PER;
        if (sts.div_done) begin
          ctl.div_cap = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/adaptive_period_meter_unit.sv
// adaptive_period_meter_unit: top level of the adaptive-threshold period meter
// depends on apm_pkg, apm_ctrl and apm_dp (which holds apm_div and apm_ram)
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// input     | in_valid/in_ready  | cmd, sample, weight
// output    | out_valid/out_ready| period_valid .. queue_level (one result per item)
// config    | psel/penable/pready| paddr, pwdata, prdata (divisor at 0, warm-up at 4)
//
// each item runs through one shared 64-step divider; a feed item does four divisions
// (average, amplitude, threshold, period average), a pop, a clear, an empty pop or any
// other command two (amplitude, period average); a new item is taken only once the last
// has been loaded into the output register
// the result waits in an output register, so the next item is taken while it stalls
// synchronous active-high reset; the queue memory is not cleared, only its pointers

module adaptive_period_meter_unit #(
  parameter int QUEUE_DEPTH = apm_pkg::QUEUE_DEPTH_DEF,
  parameter int SAMPLE_BITS = apm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = apm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // item input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [apm_pkg::CMD_W-1:0]         cmd,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic [apm_pkg::WEIGHT_W-1:0]      weight,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              period_valid,
  output logic [apm_pkg::PER_W-1:0]         last_period,
  output logic [apm_pkg::PER_W-1:0]         min_period,
  output logic [apm_pkg::PER_W-1:0]         max_period,
  output logic [apm_pkg::PER_W-1:0]         period_count,
  output logic [apm_pkg::AVGP_W-1:0]        average_period,
  output logic [apm_pkg::AMP_W-1:0]         amplitude,
  output logic                              ready_res,
  output logic                              pop_valid,
  output logic [apm_pkg::PER_W-1:0]         pop_value,
  output logic                              overflow,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apm_pkg::PADDR_W-1:0]       paddr,
  input  logic [apm_pkg::PDATA_W-1:0]       pwdata,
  output logic [apm_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import apm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // register port never stalls
  assign pready = 1'b1;

  // sequencer: walks each item through sums and edge logic (feed), pop or clear, divisions and result load
  apm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // datapath: configuration, running sums, statistics, period queue, result register
  apm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .cmd            (cmd),
    .sample         (sample),
    .weight         (weight),
    .ctl            (ctl),
    .sts            (sts),
    .period_valid   (period_valid),
    .last_period    (last_period),
    .min_period     (min_period),
    .max_period     (max_period),
    .period_count   (period_count),
    .average_period (average_period),
    .amplitude      (amplitude),
    .ready_res      (ready_res),
    .pop_valid      (pop_valid),
    .pop_value      (pop_value),
    .overflow       (overflow),
    .queue_level    (queue_level)
  );

endmodule

>>> src/apm_checker.sv
// apm_checker: port-level checks of the period meter, bound to the top level
// depends on adaptive_period_meter_unit_assert.svh and apm_pkg
`timescale 1ns / 1ps
`include "adaptive_period_meter_unit_assert.svh"

module apm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       period_valid,
  input logic                       pop_valid,
  input logic                       ready_res,
  input logic [apm_pkg::PER_W-1:0]  last_period,
  input logic [apm_pkg::PER_W-1:0]  min_period,
  input logic [apm_pkg::PER_W-1:0]  max_period,
  input logic [apm_pkg::PER_W-1:0]  period_count,
  input logic [apm_pkg::AVGP_W-1:0] average_period
);

  // a stalled item keeps its values
  `APM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(last_period) && $stable(period_count), "stalled item changed")

  // a recorded period implies statistics and excludes a pop
  `APM_ASSERT_NOW(a_rec_stats, clk, rst, out_valid && period_valid, ready_res && period_count != 0 && !pop_valid, "recorded period without statistics")

  // no period recorded: min, max, count and average period all read zero
  `APM_ASSERT_NOW(a_empty_stats, clk, rst, out_valid && !ready_res, min_period == 0 && max_period == 0 && period_count == 0 && average_period == 0, "statistics not cleared")

  // last period lies between the extremes
  `APM_ASSERT_NOW(a_order, clk, rst, out_valid && ready_res, min_period <= max_period && last_period >= min_period && last_period <= max_period, "period extremes out of order")

endmodule

bind adaptive_period_meter_unit apm_checker u_apm_checker (.*);
